// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Command codes, field widths and the stored slot entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 6;
	localparam int TIME_W  = 32;
	localparam int STAMP_W = 32;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADJUST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0]  deadline;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

`default_nettype wire

// ===== hdl/stq_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sorted_timeout_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue
// Timer slot table ordered by expiry and order stamp, with add, adjust,
// delete and tick commands. A tick fires every expired slot in order.
// ----------------------------------------------------------------------------
//
//   Beat         Handshake          Fields
//   command      start, busy        cmd, slot_id, expiry_value, current_time
//   fired slot   strobe (1 cycle)   fired_slot, last_fired
//
// One comparator walks the slot memory, one entry per cycle.
// Delete finishes on acceptance, add passes through the stamp state, and an adjust
// reads the slot, then scans for its successor. A tick runs one scan per fired slot
// plus a final scan, results spaced apart. When the stamp counter is exhausted,
// renumbering runs one scan per armed slot plus a final one. Reset clears the armed bits and the stamp counter.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timeout_queue
	import stq_pkg::*;
#(
	parameter int NUM_SLOTS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [SLOT_W-1:0] slot_id,
	input  wire logic [TIME_W-1:0] expiry_value,
	input  wire logic [TIME_W-1:0] current_time,
	output logic                   strobe,
	output logic [SLOT_W-1:0]      fired_slot,
	output logic                   last_fired
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [CW-1:0] SCAN_LAST = CW'(NUM_SLOTS);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ADJ_RD  = 3'd1;
	localparam logic [2:0] S_ADJ_KEY = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_STAMP   = 3'd4;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_SUCC  = 2'd1;
	localparam logic [1:0] MODE_RENUM = 2'd2;

	logic [2:0]           state_q;
	logic [1:0]           mode_q;
	logic [SW-1:0]        slot_q;
	logic [TIME_W-1:0]    exp_q;
	logic [TIME_W-1:0]    now_q;
	entry_t               key_s_q;
	logic [CW-1:0]        cnt_q;
	logic                 vld_s1;
	logic [SW-1:0]        idx_s1;
	logic                 best_found_q;
	logic [SW-1:0]        best_idx_q;
	entry_t               best_word_q;
	logic                 pend_q;
	logic [SW-1:0]        pend_idx_q;
	logic [NUM_SLOTS-1:0] armed_q;
	logic [NUM_SLOTS-1:0] done_q;
	logic [CW-1:0]        ren_cnt_q;
	logic [STAMP_W-1:0]   stamp_counter_q;
	logic                 strobe_q;
	logic [SLOT_W-1:0]    fired_slot_q;
	logic                 last_q;

	entry_t                   rd_data;
	logic [$bits(entry_t)-1:0] rd_raw;
	logic                     rd_en;
	logic [SW-1:0]            rd_addr;
	logic                     wr_en;
	logic [SW-1:0]            wr_addr;
	entry_t                   wr_data;

	logic                 accept;
	logic                 in_range;
	logic [SW-1:0]        sid;
	logic                 scan_end;
	logic [63:0]          key_j;
	logic [63:0]          key_b;
	logic                 filt;
	logic                 take;
	logic                 need_stamp;
	logic                 stamp_full;

	assign accept     = start && (state_q == S_IDLE);
	assign in_range   = {26'd0, slot_id} < 32'(NUM_SLOTS);
	assign sid        = SW'(slot_id);
	assign scan_end   = (state_q == S_SCAN) && (cnt_q == SCAN_LAST) && !vld_s1;
	assign need_stamp = best_found_q && (exp_q >= best_word_q.deadline);
	assign stamp_full = stamp_counter_q == '1;
	assign rd_data    = entry_t'(rd_raw);

	assign rd_en   = (state_q == S_ADJ_RD) || ((state_q == S_SCAN) && (cnt_q != SCAN_LAST));
	assign rd_addr = (state_q == S_SCAN) ? cnt_q[SW-1:0] : slot_q;

	always_comb begin
		key_j = rd_data;
		key_b = best_word_q;
		if (mode_q == MODE_RENUM) begin
			key_j = {32'd0, rd_data.stamp};
			key_b = {32'd0, best_word_q.stamp};
		end
	end

	always_comb begin
		case (mode_q)
			MODE_TICK: filt = armed_q[idx_s1] && (rd_data.deadline <= now_q);
			MODE_SUCC: filt = armed_q[idx_s1] && (idx_s1 != slot_q) && (key_s_q < key_j);
			MODE_RENUM: filt = armed_q[idx_s1] && !done_q[idx_s1];
			default: filt = 1'b0;
		endcase
	end

	assign take = vld_s1 && filt && (!best_found_q || (key_j < key_b));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = '{deadline: exp_q, stamp: stamp_counter_q};
		if (scan_end && (mode_q == MODE_RENUM) && best_found_q) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = '{deadline: best_word_q.deadline, stamp: STAMP_W'(ren_cnt_q)};
		end else if (scan_end && (mode_q == MODE_SUCC) && !need_stamp) begin
			wr_en   = 1'b1;
			wr_data = '{deadline: exp_q, stamp: key_s_q.stamp};
		end else if ((state_q == S_STAMP) && !stamp_full) begin
			wr_en = 1'b1;
		end
	end

	stq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_SLOTS)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			mode_q          <= MODE_TICK;
			cnt_q           <= '0;
			vld_s1          <= 1'b0;
			best_found_q    <= 1'b0;
			pend_q          <= 1'b0;
			armed_q         <= '0;
			done_q          <= '0;
			ren_cnt_q       <= '0;
			stamp_counter_q <= '0;
			strobe_q        <= 1'b0;
		end else begin
			strobe_q <= scan_end && (mode_q == MODE_TICK) && pend_q;
			vld_s1   <= (state_q == S_SCAN) && (cnt_q != SCAN_LAST);
			if (take) begin
				best_found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_TICK) begin
							mode_q       <= MODE_TICK;
							cnt_q        <= '0;
							best_found_q <= 1'b0;
							state_q      <= S_SCAN;
						end else if (in_range) begin
							case (cmd)
								CMD_ADD: begin
									armed_q[sid] <= 1'b0;
									state_q      <= S_STAMP;
								end
								CMD_ADJUST: begin
									if (armed_q[sid]) begin
										state_q <= S_ADJ_RD;
									end
								end
								default: begin
									armed_q[sid] <= 1'b0;
								end
							endcase
						end
					end
				end
				S_ADJ_RD: begin
					state_q <= S_ADJ_KEY;
				end
				S_ADJ_KEY: begin
					mode_q       <= MODE_SUCC;
					cnt_q        <= '0;
					best_found_q <= 1'b0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q != SCAN_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_end) begin
						case (mode_q)
							MODE_TICK: begin
								if (best_found_q) begin
									armed_q[best_idx_q] <= 1'b0;
									pend_q              <= 1'b1;
									cnt_q               <= '0;
									best_found_q        <= 1'b0;
								end else begin
									pend_q  <= 1'b0;
									state_q <= S_IDLE;
								end
							end
							MODE_SUCC: begin
								state_q <= need_stamp ? S_STAMP : S_IDLE;
							end
							default: begin
								if (best_found_q) begin
									done_q[best_idx_q] <= 1'b1;
									ren_cnt_q          <= ren_cnt_q + 1'b1;
									cnt_q              <= '0;
									best_found_q       <= 1'b0;
								end else begin
									stamp_counter_q <= STAMP_W'(ren_cnt_q);
									state_q         <= S_STAMP;
								end
							end
						endcase
					end
				end
				S_STAMP: begin
					if (stamp_full) begin
						done_q       <= '0;
						ren_cnt_q    <= '0;
						mode_q       <= MODE_RENUM;
						cnt_q        <= '0;
						best_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end else begin
						stamp_counter_q <= stamp_counter_q + 1'b1;
						armed_q[slot_q] <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= sid;
			exp_q  <= expiry_value;
			now_q  <= current_time;
		end
		if (state_q == S_ADJ_KEY) begin
			key_s_q <= rd_data;
		end
		idx_s1 <= cnt_q[SW-1:0];
		if (take) begin
			best_idx_q  <= idx_s1;
			best_word_q <= rd_data;
		end
		if (scan_end && (mode_q == MODE_TICK)) begin
			fired_slot_q <= SLOT_W'(pend_idx_q);
			last_q       <= !best_found_q;
			if (best_found_q) begin
				pend_idx_q <= best_idx_q;
			end
		end
	end

	assign busy       = state_q != S_IDLE;
	assign strobe     = strobe_q;
	assign fired_slot = fired_slot_q;
	assign last_fired = last_q;

	a_strobe_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == S_SCAN))
		else $error("result beat without a finished scan");

	a_fired_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_end && (mode_q == MODE_TICK) && pend_q) |-> !armed_q[pend_idx_q])
		else $error("fired slot is still armed");

	a_renumber_frees: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_STAMP) && $past(state_q == S_SCAN) && $past(mode_q == MODE_RENUM))
		|-> !stamp_full)
		else $error("stamp counter still exhausted after renumbering");

endmodule

`default_nettype wire
